>>> src/ppie_pkg.sv
// ----------------------------------------------------------------------------
// ppie_pkg
// Shared constants, item types and field-width helpers for the packed palette
// index extractor.
// ----------------------------------------------------------------------------
package ppie_pkg;

  // Store and palette limits
  localparam int STORE_WORDS = 1024;
  localparam int MAX_PALETTE = 4096;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  // Field widths of the item payload
  localparam int POS_W   = 12;   // (y*16+z)*16+x
  localparam int WIDX_W  = 10;
  localparam int WORD_W  = 64;
  localparam int SIZE_W  = 13;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 12;
  localparam int FW_W    = 4;    // field width, 0 when unfit
  localparam int PER_W   = 5;    // fields per aligned word
  localparam int RCP_W   = 14;   // reciprocal of fields per word, Q16
  localparam int RCP_SH  = 16;
  localparam int BIT_W   = POS_W + FW_W;       // stream bit position
  localparam int OFF_W   = $clog2(WORD_W);     // bit offset in a word
  localparam int WI_W    = BIT_W - OFF_W;      // word number
  localparam int Q_W     = POS_W + RCP_W - RCP_SH;
  localparam int REM_W   = 6;    // remainder before correction, below 32

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PALETTE_SIZE   = 2'd0,
    REG_WORD_COUNT     = 2'd1,
    REG_STREAM_PACKING = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // Item as accepted at the input
  typedef struct packed {
    op_t                op;
    logic [WIDX_W-1:0]  widx;
    logic [WORD_W-1:0]  wval;
    logic [POS_W-1:0]   pos;
  } req_t;

  // Item after word location, ready for the store read
  typedef struct packed {
    op_t                op;
    logic [WIDX_W-1:0]  widx;
    logic [WORD_W-1:0]  wval;
    logic [WI_W-1:0]    wi;
    logic [OFF_W-1:0]   off;
    logic               wi_ok;     // first word inside the count
    logic               nxt_ok;    // second word inside the count
    logic               straddle;  // field runs into the next word
  } loc_t;

  // Field width for a palette size; 0 when mode and size do not fit
  function automatic logic [FW_W-1:0] field_width(input logic [SIZE_W-1:0] size,
                                                  input logic              stream);
    logic [FW_W-1:0] w;
    if (size > SIZE_W'(MAX_PALETTE))     w = 4'd0;
    else if (size <= SIZE_W'(16))        w = 4'd4;
    else if (size <= SIZE_W'(32))        w = 4'd5;
    else if (size <= SIZE_W'(64))        w = 4'd6;
    else if (size <= SIZE_W'(128))       w = 4'd7;
    else if (size <= SIZE_W'(256))       w = 4'd8;
    else if (size <= SIZE_W'(512))       w = 4'd9;
    else if (size <= SIZE_W'(1024))      w = 4'd10;
    else if (size <= SIZE_W'(2048))      w = 4'd11;
    else                                 w = 4'd12;
    if (stream && (w == 4'd4 || w == 4'd8))
      w = 4'd0;
    return w;
  endfunction

  // Fields held by one aligned word: floor(64 / width)
  function automatic logic [PER_W-1:0] fields_per_word(input logic [FW_W-1:0] w);
    logic [PER_W-1:0] p;
    unique case (w)
      4'd5:    p = 5'd12;
      4'd6:    p = 5'd10;
      4'd7:    p = 5'd9;
      4'd8:    p = 5'd8;
      4'd9:    p = 5'd7;
      4'd10:   p = 5'd6;
      4'd11:   p = 5'd5;
      4'd12:   p = 5'd5;
      default: p = 5'd16;
    endcase
    return p;
  endfunction

  // floor(65536 / fields_per_word); the quotient it gives is low by at most one
  function automatic logic [RCP_W-1:0] per_recip(input logic [FW_W-1:0] w);
    logic [RCP_W-1:0] r;
    unique case (w)
      4'd5:    r = 14'd5461;
      4'd6:    r = 14'd6553;
      4'd7:    r = 14'd7281;
      4'd8:    r = 14'd8192;
      4'd9:    r = 14'd9362;
      4'd10:   r = 14'd10922;
      4'd11:   r = 14'd13107;
      4'd12:   r = 14'd13107;
      default: r = 14'd4096;
    endcase
    return r;
  endfunction

endpackage

>>> src/ppie_locate.sv
// ----------------------------------------------------------------------------
// ppie_locate
// Three-stage pipeline that turns a field number into a store word number,
// a bit offset and range flags, for both aligned and stream packing.
// ----------------------------------------------------------------------------
module ppie_locate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ppie_pkg::FW_W-1:0]   width,
  input  logic                        stream,
  input  logic [ppie_pkg::CNT_W-1:0]  word_count,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ppie_pkg::req_t              in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ppie_pkg::loc_t              out_item
);

  localparam int PROD_W = ppie_pkg::POS_W + ppie_pkg::RCP_W;
  localparam int QP_W   = ppie_pkg::Q_W + ppie_pkg::PER_W;
  localparam int NXT_W  = ppie_pkg::WI_W + 1;

  // Stage valid bits and per-stage ready
  logic va_r, vb_r, vc_r;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c    = !vc_r || out_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  // Stage A: stream bit position and estimated aligned quotient
  ppie_pkg::req_t                 a_req_r;
  logic [ppie_pkg::BIT_W-1:0]     a_bit_r;
  logic [ppie_pkg::Q_W-1:0]       a_q0_r;
  logic [PROD_W-1:0]              a_prod;

  assign a_prod = PROD_W'(in_item.pos) * PROD_W'(ppie_pkg::per_recip(width));

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_req_r <= in_item;
      a_bit_r <= ppie_pkg::BIT_W'(in_item.pos) * ppie_pkg::BIT_W'(width);
      a_q0_r  <= a_prod[PROD_W-1:ppie_pkg::RCP_SH];
    end
  end

  // Stage B: remainder against the estimate, below twice fields per word
  ppie_pkg::req_t                 b_req_r;
  logic [ppie_pkg::BIT_W-1:0]     b_bit_r;
  logic [ppie_pkg::Q_W-1:0]       b_q0_r;
  logic [ppie_pkg::REM_W-1:0]     b_rem_r;
  logic [QP_W-1:0]                b_qp;
  logic [QP_W-1:0]                b_diff;

  assign b_qp   = QP_W'(a_q0_r) * QP_W'(ppie_pkg::fields_per_word(width));
  assign b_diff = QP_W'(a_req_r.pos) - b_qp;

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_req_r <= a_req_r;
      b_bit_r <= a_bit_r;
      b_q0_r  <= a_q0_r;
      b_rem_r <= b_diff[ppie_pkg::REM_W-1:0];
    end
  end

  // Stage C: correct quotient, pick word and offset, check the word count
  logic [ppie_pkg::PER_W-1:0]     c_per;
  logic                           c_fix;
  logic [ppie_pkg::FW_W-1:0]      c_slot;
  logic [7:0]                     c_slot_off;
  logic [ppie_pkg::WI_W-1:0]      c_wi;
  logic [ppie_pkg::OFF_W-1:0]     c_off;
  logic [NXT_W-1:0]               c_nxt;
  logic [ppie_pkg::OFF_W:0]       c_end;
  logic                           c_straddle;
  ppie_pkg::loc_t                 c_item_r;

  always_comb begin
    c_per      = ppie_pkg::fields_per_word(width);
    c_fix      = b_rem_r >= ppie_pkg::REM_W'(c_per);
    c_slot     = c_fix ? ppie_pkg::FW_W'(b_rem_r - ppie_pkg::REM_W'(c_per))
                       : ppie_pkg::FW_W'(b_rem_r);
    c_slot_off = 8'(c_slot) * 8'(width);
    if (stream) begin
      c_wi  = b_bit_r[ppie_pkg::BIT_W-1:ppie_pkg::OFF_W];
      c_off = b_bit_r[ppie_pkg::OFF_W-1:0];
    end else begin
      c_wi  = ppie_pkg::WI_W'(b_q0_r) + ppie_pkg::WI_W'(c_fix);
      c_off = c_slot_off[ppie_pkg::OFF_W-1:0];
    end
    c_nxt      = NXT_W'(c_wi) + NXT_W'(1);
    c_end      = (ppie_pkg::OFF_W+1)'(c_off) + (ppie_pkg::OFF_W+1)'(width);
    c_straddle = stream && (c_end > (ppie_pkg::OFF_W+1)'(ppie_pkg::WORD_W));
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_item_r.op       <= b_req_r.op;
      c_item_r.widx     <= b_req_r.widx;
      c_item_r.wval     <= b_req_r.wval;
      c_item_r.wi       <= c_wi;
      c_item_r.off      <= c_off;
      c_item_r.straddle <= c_straddle;
      c_item_r.wi_ok    <= (ppie_pkg::CNT_W'(c_wi) < word_count) &&
                           (32'(c_wi) < ppie_pkg::STORE_WORDS);
      c_item_r.nxt_ok   <= (ppie_pkg::CNT_W'(c_nxt) < word_count) &&
                           (32'(c_nxt) < ppie_pkg::STORE_WORDS);
    end
  end

  assign out_valid = vc_r;
  assign out_item  = c_item_r;

endmodule

>>> src/packed_palette_index_extract.sv
// ----------------------------------------------------------------------------
// packed_palette_index_extract
// Word store of packed bit fields with a pipelined field lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries two kinds of item. A load item
//   (in_operation 0) writes in_word_value to store word in_word_index and
//   gives no result. A lookup item (in_operation 1) reads the field at
//   position (in_pos_x, in_pos_z, in_pos_y) and gives one result item on the
//   output channel (out_valid / out_stall): out_found and out_palette_index.
//   The cfg_ port sets palette size, word count and packing mode; write it
//   only while no items are in flight.
//   Throughput: one item per cycle while out_stall is low, loads and lookups
//   mixed freely. A lookup item passes through the input register,
//   three locate stages, the store read and the output register.
//   Loads take effect in the store-read stage, in item order with lookups.
//   Reset clears the configuration and the pipeline valid bits. Store
//   contents are undefined until loaded; there is no clearing pass.
//   When the receiver stalls, each stage keeps its item and empty stages
//   behind it keep filling; in_stall rises once the pipeline is full.
// ----------------------------------------------------------------------------
module packed_palette_index_extract (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [ppie_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppie_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic [ppie_pkg::WIDX_W-1:0]        in_word_index,
  input  logic [ppie_pkg::WORD_W-1:0]        in_word_value,
  input  logic [3:0]                         in_pos_x,
  input  logic [3:0]                         in_pos_z,
  input  logic [3:0]                         in_pos_y,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [ppie_pkg::IDX_W-1:0]         out_palette_index
);

  // Configuration registers
  logic [ppie_pkg::SIZE_W-1:0] palette_size_r;
  logic [ppie_pkg::CNT_W-1:0]  word_count_r;
  logic                        stream_r;
  logic [ppie_pkg::FW_W-1:0]   width;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_size_r <= '0;
      word_count_r   <= '0;
      stream_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (ppie_pkg::cfg_reg_t'(cfg_index))
        ppie_pkg::REG_PALETTE_SIZE:   palette_size_r <= cfg_data[ppie_pkg::SIZE_W-1:0];
        ppie_pkg::REG_WORD_COUNT:     word_count_r   <= cfg_data[ppie_pkg::CNT_W-1:0];
        ppie_pkg::REG_STREAM_PACKING: stream_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign width = ppie_pkg::field_width(palette_size_r, stream_r);

  // Handshake: ready of each stage from the output back to the input
  logic out_v_r, mem_v_r, in_v_r;
  logic out_rdy, mem_rdy, in_rdy;
  logic loc_in_ready, loc_valid;
  ppie_pkg::loc_t loc_item;

  assign out_rdy  = !out_v_r || !out_stall;
  assign mem_rdy  = !mem_v_r || out_rdy;
  assign in_rdy   = !in_v_r || loc_in_ready;
  assign in_stall = !in_rdy;

  // Input register
  ppie_pkg::req_t in_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else if (in_rdy) in_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      in_req_r.op   <= ppie_pkg::op_t'(in_operation);
      in_req_r.widx <= in_word_index;
      in_req_r.wval <= in_word_value;
      in_req_r.pos  <= {in_pos_y, in_pos_z, in_pos_x};
    end
  end

  // Word location
  ppie_locate u_locate (
    .clk        (clk),
    .rst_n      (rst_n),
    .width      (width),
    .stream     (stream_r),
    .word_count (word_count_r),
    .in_valid   (in_v_r),
    .in_ready   (loc_in_ready),
    .in_item    (in_req_r),
    .out_valid  (loc_valid),
    .out_ready  (mem_rdy),
    .out_item   (loc_item)
  );

  // Store access: loads write here, lookups read two adjacent words
  logic [ppie_pkg::WORD_W-1:0] word_store [ppie_pkg::STORE_WORDS];
  logic [ppie_pkg::WORD_W-1:0] rd0_r, rd1_r;
  logic [ppie_pkg::OFF_W-1:0]  mem_off_r;
  logic                        mem_ok_r;
  logic                        mem_wr, mem_rd;
  logic [ppie_pkg::ADDR_W-1:0] rd_addr0, rd_addr1;

  assign mem_wr   = loc_valid && mem_rdy && (loc_item.op == ppie_pkg::OP_LOAD) &&
                    (32'(loc_item.widx) < ppie_pkg::STORE_WORDS);
  assign mem_rd   = loc_valid && mem_rdy && (loc_item.op == ppie_pkg::OP_LOOKUP);
  assign rd_addr0 = ppie_pkg::ADDR_W'(loc_item.wi);
  assign rd_addr1 = rd_addr0 + ppie_pkg::ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (mem_wr)
      word_store[ppie_pkg::ADDR_W'(loc_item.widx)] <= loc_item.wval;
    if (mem_rd) begin
      rd0_r     <= word_store[rd_addr0];
      rd1_r     <= word_store[rd_addr1];
      mem_off_r <= loc_item.off;
      mem_ok_r  <= loc_item.wi_ok && (!loc_item.straddle || loc_item.nxt_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mem_v_r <= 1'b0;
    else if (mem_rdy) mem_v_r <= mem_rd;
  end

  // Field extract and palette bound check
  logic [2*ppie_pkg::WORD_W-1:0] pair_shift;
  logic [ppie_pkg::IDX_W-1:0]    field_mask;
  logic [ppie_pkg::IDX_W-1:0]    field_val;
  logic                          field_ok;
  logic                          found_r;
  logic [ppie_pkg::IDX_W-1:0]    index_r;

  always_comb begin
    pair_shift = {rd1_r, rd0_r} >> mem_off_r;
    field_mask = ppie_pkg::IDX_W'((13'd1 << width) - 13'd1);
    field_val  = pair_shift[ppie_pkg::IDX_W-1:0] & field_mask;
    field_ok   = mem_ok_r && (width != '0) &&
                 (ppie_pkg::SIZE_W'(field_val) < palette_size_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_rdy) out_v_r <= mem_v_r;
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      found_r <= field_ok;
      index_r <= field_ok ? field_val : '0;
    end
  end

  assign out_valid         = out_v_r;
  assign out_found         = found_r;
  assign out_palette_index = index_r;

endmodule
